// ----- hdl/lsrf_pkg.sv -----
// Shared types, constants and glyph helpers for the LCD segment reading formatter.
package lsrf_pkg;

    localparam int IMAGE_W   = 64;
    localparam int READING_W = 18;
    localparam int X10_W     = 14;
    localparam int DIGIT_W   = 4;
    localparam int PAT_W     = 7;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ALL_ON = 3'd1,
        CMD_TEMP   = 3'd2,
        CMD_HUMI   = 3'd3,
        CMD_ICON   = 3'd4,
        CMD_BATT   = 3'd5,
        CMD_SIGNAL = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    // How the three temperature digits are laid out
    typedef enum logic [1:0] {
        FORM_POS_FRAC = 2'd0,   // " d.d" or "dd.d"
        FORM_POS_INT  = 2'd1,   // "ddd"
        FORM_NEG_FRAC = 2'd2,   // "-d.d"
        FORM_NEG_INT  = 2'd3    // "-dd"
    } form_t;

    typedef struct packed {
        form_t              form;
        logic               humi_full;
        logic [X10_W-1:0]   value;
    } scale_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] thousands;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } digits_t;

    localparam logic [PAT_W-1:0] PAT_BLANK = 7'h00;
    localparam logic [PAT_W-1:0] PAT_MINUS = 7'h40;

    localparam logic [READING_W-1:0] HUMI_CLAMP = 18'd10000;
    localparam logic [X10_W-1:0]     HUMI_FULL  = 14'd9950;
    localparam logic [X10_W-1:0]     ROUND_HALF = 14'd5;

    localparam logic [X10_W-1:0] NEG_FRAC_LIMIT = 14'd100;
    localparam logic [X10_W-1:0] NEG_CLAMP_X10  = 14'd994;
    localparam logic [X10_W-1:0] POS_INT_LIMIT  = 14'd1000;
    localparam logic [X10_W-1:0] POS_CLAMP_X10  = 14'd9999;

    // Reciprocals for divide-by-constant; exact over the ranges used
    localparam logic [17:0] RECIP10_Q21   = 18'd209716;
    localparam logic [13:0] RECIP10_Q17   = 14'd13108;
    localparam logic [13:0] RECIP100_Q20  = 14'd10486;
    localparam logic [14:0] RECIP1000_Q24 = 15'd16778;

    localparam logic [3:0] ICON_MIN     = 4'd1;
    localparam logic [3:0] ICON_MAX     = 4'd9;
    localparam logic [3:0] BATT_FIRST   = 4'd6;
    localparam logic [3:0] SIGNAL_FIRST = 4'd2;

    localparam logic [5:0] CELSIUS_BIT = 6'd28;
    localparam logic [5:0] PERCENT_BIT = 6'd52;

    function automatic logic [PAT_W-1:0] seg_glyph(input logic [DIGIT_W-1:0] d);
        logic [PAT_W-1:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = PAT_BLANK;
        endcase
        return g;
    endfunction

    // Pattern bits 0..6 are A..G; byte is D,E,G,F,DP,C,B,A from bit 0 up
    function automatic logic [7:0] digit_byte(input logic [PAT_W-1:0] pat, input logic dp);
        return {pat[0], pat[1], pat[2], dp, pat[5], pat[6], pat[4], pat[3]};
    endfunction

    function automatic logic [5:0] icon_bit(input logic [3:0] num);
        logic [5:0] b;
        case (num)
            4'd1:    b = 6'd36;
            4'd2:    b = 6'd63;
            4'd3:    b = 6'd62;
            4'd4:    b = 6'd61;
            4'd5:    b = 6'd60;
            4'd6:    b = 6'd56;
            4'd7:    b = 6'd59;
            4'd8:    b = 6'd58;
            4'd9:    b = 6'd57;
            default: b = 6'd0;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/lsrf_scale.sv -----
// Rounds a reading to tenths and picks the temperature layout and the value to split.
module lsrf_scale
    import lsrf_pkg::*;
(
    input  cmd_t                         cmd,
    input  logic signed [READING_W-1:0]  reading,
    output scale_t                       scale
);

    logic [READING_W-1:0]   reading_u;
    logic [READING_W-1:0]   mag;
    logic [X10_W-1:0]       humi;
    logic [READING_W-1:0]   dividend;
    logic [2*READING_W-1:0] prod;
    logic [X10_W-1:0]       x10;

    assign reading_u = reading;
    assign mag       = reading_u[READING_W-1] ? (~reading_u + 18'd1) : reading_u;

    always_comb
    begin
        if (reading_u[READING_W-1])
        begin
            humi = '0;
        end
        else if (reading_u > HUMI_CLAMP)
        begin
            humi = HUMI_CLAMP[X10_W-1:0];
        end
        else
        begin
            humi = reading_u[X10_W-1:0];
        end
    end

    // One shared divide by ten for both kinds of reading
    assign dividend = (cmd == CMD_HUMI) ? (READING_W'(humi) + READING_W'(ROUND_HALF))
                                        : (mag + READING_W'(ROUND_HALF));
    assign prod     = (2*READING_W)'(dividend) * (2*READING_W)'(RECIP10_Q21);
    assign x10      = prod[X10_W+20:21];

    always_comb
    begin
        scale.humi_full = (humi >= HUMI_FULL);
        if (reading_u[READING_W-1] && (x10 != '0))
        begin
            if (x10 < NEG_FRAC_LIMIT)
            begin
                scale.form  = FORM_NEG_FRAC;
                scale.value = x10;
            end
            else
            begin
                // Round tenths to whole degrees again; split of value+5 gives n/10, n%10
                scale.form  = FORM_NEG_INT;
                scale.value = ((x10 > NEG_CLAMP_X10) ? NEG_CLAMP_X10 : x10) + ROUND_HALF;
            end
        end
        else if (x10 >= POS_INT_LIMIT)
        begin
            scale.form  = FORM_POS_INT;
            scale.value = (x10 > POS_CLAMP_X10) ? POS_CLAMP_X10 : x10;
        end
        else
        begin
            scale.form  = FORM_POS_FRAC;
            scale.value = x10;
        end
    end

endmodule

// ----- hdl/lsrf_digit_split.sv -----
// Splits a value below ten thousand into four decimal digits.
module lsrf_digit_split
    import lsrf_pkg::*;
(
    input  logic [X10_W-1:0] value,
    output digits_t          digits
);

    logic [28:0]      prod_k;
    logic [27:0]      prod_h;
    logic [27:0]      prod_t;
    logic [3:0]       quo_k;
    logic [6:0]       quo_h;
    logic [9:0]       quo_t;
    logic [6:0]       rem_h;
    logic [9:0]       rem_t;
    logic [X10_W-1:0] rem_u;

    // Three parallel quotients; thousands is the top quotient, each lower digit a difference of neighbors
    assign prod_k = 29'(value) * 29'(RECIP1000_Q24);
    assign prod_h = 28'(value) * 28'(RECIP100_Q20);
    assign prod_t = 28'(value) * 28'(RECIP10_Q17);

    assign quo_k = prod_k[27:24];
    assign quo_h = prod_h[26:20];
    assign quo_t = prod_t[26:17];

    assign rem_h = quo_h - 7'(quo_k) * 7'd10;
    assign rem_t = quo_t - 10'(quo_h) * 10'd10;
    assign rem_u = value - X10_W'(quo_t) * 14'd10;

    assign digits.thousands = quo_k;
    assign digits.hundreds  = rem_h[DIGIT_W-1:0];
    assign digits.tens      = rem_t[DIGIT_W-1:0];
    assign digits.units     = rem_u[DIGIT_W-1:0];

endmodule

// ----- hdl/lcd_segment_reading_formatter.sv -----
// Top level: three-register pipeline that applies display commands to a 64-bit LCD image.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------------------
//   command   | valid / stall              | cmd, reading, icon_number, icon_on, bar_level
//   image     | image_valid / image_stall  | segment_image
//
// One word per cycle sustained while the image port does not stall; a command reaches the
// image port through the input register, scale register and image register.
// The image register is the display state: clear and all-on overwrite it, others rewrite their own bits.
// Reset clears the image and empties every stage.
// A stall on the image port backs up stage by stage; the command port stalls only when
// the input register is full and cannot move on.
module lcd_segment_reading_formatter
    import lsrf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    output logic                        stall,
    input  logic [2:0]                  cmd,
    input  logic signed [READING_W-1:0] reading,
    input  logic [3:0]                  icon_number,
    input  logic                        icon_on,
    input  logic [2:0]                  bar_level,
    output logic                        image_valid,
    input  logic                        image_stall,
    output logic [IMAGE_W-1:0]          segment_image
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    cmd_t                        s1_cmd_reg;
    logic signed [READING_W-1:0] s1_reading_reg;
    logic [3:0]                  s1_icon_number_reg;
    logic                        s1_icon_on_reg;
    logic [2:0]                  s1_bar_level_reg;

    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    cmd_t                        s2_cmd_reg;
    scale_t                      s2_scale_reg;
    logic [3:0]                  s2_icon_number_reg;
    logic                        s2_icon_on_reg;
    logic [2:0]                  s2_bar_level_reg;

    logic                        image_valid_reg;
    logic                        image_valid_next;
    logic [IMAGE_W-1:0]          display_image_reg;
    logic [IMAGE_W-1:0]          display_image_next;

    logic                        s1_ready;
    logic                        s2_ready;
    logic                        s3_ready;
    logic                        s3_load;

    scale_t                      scale;
    digits_t                     digits;

    logic [PAT_W-1:0]            t_pat0;
    logic [PAT_W-1:0]            t_pat1;
    logic [PAT_W-1:0]            t_pat2;
    logic                        t_dp;
    logic [7:0]                  h_byte4;
    logic [7:0]                  h_byte5;
    logic [7:0]                  h_byte6;

    // ---------------- flow control ----------------
    assign s3_ready = !image_valid_reg || !image_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s3_load  = s2_valid_reg && s3_ready;
    assign stall    = !s1_ready;

    assign s1_valid_next    = s1_ready ? valid : s1_valid_reg;
    assign s2_valid_next    = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign image_valid_next = s3_ready ? s2_valid_reg : image_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            image_valid_reg   <= 1'b0;
            display_image_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            image_valid_reg <= image_valid_next;
            if (s3_load)
            begin
                display_image_reg <= display_image_next;
            end
        end
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_cmd_reg         <= cmd_t'(cmd);
            s1_reading_reg     <= reading;
            s1_icon_number_reg <= icon_number;
            s1_icon_on_reg     <= icon_on;
            s1_bar_level_reg   <= bar_level;
        end
    end

    lsrf_scale u_scale (
        .cmd     (s1_cmd_reg),
        .reading (s1_reading_reg),
        .scale   (scale)
    );

    // ---------------- stage 2: rounded value ----------------
    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_cmd_reg         <= s1_cmd_reg;
            s2_scale_reg       <= scale;
            s2_icon_number_reg <= s1_icon_number_reg;
            s2_icon_on_reg     <= s1_icon_on_reg;
            s2_bar_level_reg   <= s1_bar_level_reg;
        end
    end

    lsrf_digit_split u_digit_split (
        .value  (s2_scale_reg.value),
        .digits (digits)
    );

    always_comb
    begin
        case (s2_scale_reg.form)
            FORM_POS_INT:
            begin
                t_pat0 = seg_glyph(digits.thousands);
                t_pat1 = seg_glyph(digits.hundreds);
                t_pat2 = seg_glyph(digits.tens);
                t_dp   = 1'b0;
            end
            FORM_NEG_FRAC:
            begin
                t_pat0 = PAT_MINUS;
                t_pat1 = seg_glyph(digits.tens);
                t_pat2 = seg_glyph(digits.units);
                t_dp   = 1'b1;
            end
            FORM_NEG_INT:
            begin
                t_pat0 = PAT_MINUS;
                t_pat1 = seg_glyph(digits.hundreds);
                t_pat2 = seg_glyph(digits.tens);
                t_dp   = 1'b0;
            end
            default:
            begin
                // blank the leading digit below ten degrees
                t_pat0 = (digits.hundreds != '0) ? seg_glyph(digits.hundreds) : PAT_BLANK;
                t_pat1 = seg_glyph(digits.tens);
                t_pat2 = seg_glyph(digits.units);
                t_dp   = 1'b1;
            end
        endcase
    end

    // The DP slot of digit 6 is the percent icon, so it is always lit here
    always_comb
    begin
        if (s2_scale_reg.humi_full)
        begin
            h_byte4 = digit_byte(seg_glyph(4'd1), 1'b0);
            h_byte5 = digit_byte(seg_glyph(4'd0), 1'b0);
            h_byte6 = digit_byte(seg_glyph(4'd0), 1'b1);
        end
        else
        begin
            h_byte4 = digit_byte(seg_glyph(digits.hundreds), 1'b0);
            h_byte5 = digit_byte(seg_glyph(digits.tens), 1'b1);
            h_byte6 = digit_byte(seg_glyph(digits.units), 1'b1);
        end
    end

    // ---------------- stage 3: image update ----------------
    always_comb
    begin
        display_image_next = display_image_reg;
        case (s2_cmd_reg)
            CMD_CLEAR:
            begin
                display_image_next = '0;
            end
            CMD_ALL_ON:
            begin
                display_image_next = '1;
            end
            CMD_TEMP:
            begin
                // digit 3 is blank; its DP slot is the Celsius icon
                display_image_next[31:0] = {digit_byte(PAT_BLANK, 1'b1),
                                            digit_byte(t_pat2, 1'b0),
                                            digit_byte(t_pat1, t_dp),
                                            digit_byte(t_pat0, 1'b0)};
            end
            CMD_HUMI:
            begin
                display_image_next[55:32] = {h_byte6, h_byte5, h_byte4};
            end
            CMD_ICON:
            begin
                if ((s2_icon_number_reg >= ICON_MIN) && (s2_icon_number_reg <= ICON_MAX))
                begin
                    display_image_next[icon_bit(s2_icon_number_reg)] = s2_icon_on_reg;
                end
            end
            CMD_BATT:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    display_image_next[icon_bit(BATT_FIRST + 4'(k))] =
                        (s2_bar_level_reg > 3'(k));
                end
            end
            CMD_SIGNAL:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    display_image_next[icon_bit(SIGNAL_FIRST + 4'(k))] =
                        (s2_bar_level_reg > 3'(k));
                end
            end
            default:
            begin
                display_image_next = display_image_reg;
            end
        endcase
    end

    assign image_valid   = image_valid_reg;
    assign segment_image = display_image_reg;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> (s1_valid_reg && s2_valid_reg && image_valid_reg))
        else $error("command port stalled with a free stage");

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((digits.thousands <= 4'd9) && (digits.hundreds <= 4'd9) &&
                          (digits.tens <= 4'd9) && (digits.units <= 4'd9)))
        else $error("digit split produced a non-decimal digit");

    a_celsius_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_load && (s2_cmd_reg == CMD_TEMP)) |=> display_image_reg[CELSIUS_BIT])
        else $error("temperature word left the Celsius icon dark");

    a_percent_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_load && (s2_cmd_reg == CMD_HUMI)) |=> display_image_reg[PERCENT_BIT])
        else $error("humidity word left the percent icon dark");

endmodule
